// ===== sv/char_ngram_hash_vectorizer_assert.svh =====
// assertion macros shared by the vectorizer rtl
`ifndef CHAR_NGRAM_HASH_VECTORIZER_ASSERT_SVH
`define CHAR_NGRAM_HASH_VECTORIZER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define CNHV_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define CNHV_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/cnhv_pkg.sv =====
package cnhv_pkg;

	// feature store geometry; the hash takes the low index bits, so this stays a power of two
	localparam int DIMENSIONS     = 256;
	localparam int BIN_AW         = $clog2(DIMENSIONS);
	localparam int BIN_W          = 15;
	localparam logic [BIN_W-1:0] BIN_MAX = '1;

	// text length limit and counter width
	localparam int MAX_TEXT_CHARS = 4096;
	localparam int CNT_W          = 13;

	// field and accumulator widths
	localparam int CHAR_W         = 16;
	localparam int VALUE_W        = 16;
	localparam int SUM_W          = 32;
	localparam int INV_W          = 24;

	// hash multipliers, reduced to the index width
	localparam int HASH_B         = 31;
	localparam int HASH_A         = 961 % DIMENSIONS;

	// read scaling: bin * inv >> FRAC_SHIFT gives q1.15
	localparam int PROD_W         = BIN_W + INV_W;
	localparam int FRAC_SHIFT     = INV_W - 15;
	localparam int ONE_Q15        = 32768;

	// inverse square root unit: 2^(2*INV_W) / sum, then an integer root
	localparam int DIV_STEPS      = 2 * INV_W + 1;
	localparam int ROOT_W         = INV_W + 1;
	localparam int SQRT_STEPS     = ROOT_W;
	localparam int QUO_W          = 2 * ROOT_W;
	localparam int STEP_W         = $clog2(DIV_STEPS);
	localparam int SUB_W          = SUM_W + 2;

	// request operation codes
	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_CHAR  = 2'd1,
		OP_READ  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	// result kinds
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_BIN    = 1'b1;

	// top-level sequencer
	typedef enum logic [2:0] {
		VS_IDLE,
		VS_ADD,
		VS_LOOK,
		VS_NORM,
		VS_WAIT,
		VS_STAT,
		VS_MUL,
		VS_OUT
	} vec_state_t;

	// inverse square root sequencer
	typedef enum logic [1:0] {
		RS_IDLE,
		RS_DIV,
		RS_SQRT,
		RS_DONE
	} rs_phase_t;

endpackage

// ===== sv/cnhv_if.sv =====
// request channel
interface cnhv_in_if import cnhv_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        operation;
	logic [CHAR_W-1:0] char_code;
	logic              last_char;
	logic [BIN_AW-1:0] bin_index;

	modport source (output valid, operation, char_code, last_char, bin_index, input ready);
	modport sink   (input valid, operation, char_code, last_char, bin_index, output ready);
endinterface

// result channel
interface cnhv_out_if import cnhv_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               result_kind;
	logic [VALUE_W-1:0] bin_value;
	logic [CNT_W-1:0]   chars_seen;
	logic               saturated;

	modport source (output valid, result_kind, bin_value, chars_seen, saturated, input ready);
	modport sink   (input valid, result_kind, bin_value, chars_seen, saturated, output ready);
endinterface

// ===== sv/cnhv_rsqrt.sv =====
module cnhv_rsqrt import cnhv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] sum,
	output logic             done,
	output logic [INV_W-1:0] value
);

	rs_phase_t         phase_q, phase_d;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  div_q;
	logic [SUM_W:0]    rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [ROOT_W-1:0] root_q;

	logic [SUB_W-1:0]  op_a, op_b, diff;
	logic              ge;
	logic              last_step;

	// shared subtractor: restoring divide step or root digit step
	always_comb begin
		if (phase_q == RS_SQRT) begin
			op_a = SUB_W'({rem_q[ROOT_W:0], quo_q[QUO_W-1 -: 2]});
			op_b = SUB_W'({root_q, 2'b01});
		end else begin
			op_a = {1'b0, rem_q[SUM_W-1:0], (step_q == STEP_W'(DIV_STEPS - 1))};
			op_b = SUB_W'(div_q);
		end
		diff = op_a - op_b;
		ge   = ~diff[SUB_W-1];
	end

	assign last_step = (step_q == '0);

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			RS_IDLE: if (start) phase_d = RS_DIV;
			RS_DIV:  if (last_step) phase_d = RS_SQRT;
			RS_SQRT: if (last_step) phase_d = RS_DONE;
			RS_DONE: phase_d = RS_IDLE;
		endcase
	end

	// outputs; the root saturates to the inverse width
	always_comb begin
		done  = (phase_q == RS_DONE);
		value = root_q[ROOT_W-1] ? '1 : root_q[INV_W-1:0];
	end

	// phase and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= RS_IDLE;
			step_q  <= '0;
		end else begin
			phase_q <= phase_d;
			if (phase_q == RS_IDLE && start) begin
				step_q <= STEP_W'(DIV_STEPS - 1);
			end else if (phase_q == RS_DIV && last_step) begin
				step_q <= STEP_W'(SQRT_STEPS - 1);
			end else if (phase_q == RS_DIV || phase_q == RS_SQRT) begin
				step_q <= step_q - 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (phase_q)
			RS_IDLE: begin
				if (start) begin
					div_q <= sum;
					rem_q <= '0;
					quo_q <= '0;
				end
			end
			RS_DIV: begin
				quo_q  <= {quo_q[QUO_W-2:0], ge};
				root_q <= '0;
				if (last_step) begin
					rem_q <= '0;
				end else begin
					rem_q <= ge ? diff[SUM_W:0] : op_a[SUM_W:0];
				end
			end
			RS_SQRT: begin
				quo_q  <= {quo_q[QUO_W-3:0], 2'b00};
				root_q <= {root_q[ROOT_W-2:0], ge};
				rem_q  <= ge ? diff[SUM_W:0] : op_a[SUM_W:0];
			end
			RS_DONE: begin
			end
		endcase
	end

endmodule

// ===== sv/char_ngram_hash_vectorizer.sv =====
// Hashed character n-gram vectorizer. Characters arrive one per request and are
// lower-cased for ASCII A-Z; each bigram adds 2 and each trigram adds 3 half-units
// to one of 256 saturating 15-bit bins, with a running sum of squares. A character
// marked last triggers the inverse norm and returns a status result; a read returns
// one bin scaled to unsigned Q1.15. Clear empties the store through per-bin valid
// bits. Work per request: a clear or no-op, the first character of a text and a
// character past the length limit finish on acceptance; the second adds a bigram,
// later characters a bigram and a trigram (read then write of each bin); a read goes
// through bin read, multiply and result load; a last character adds start, 49 divide
// steps, 25 root steps, value capture and status load, or only the norm check and
// status load when the sum of squares is zero. A result that waits for the receiver
// holds the block in its final state. The request side is not ready during that work.
`include "char_ngram_hash_vectorizer_assert.svh"

module char_ngram_hash_vectorizer import cnhv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	cnhv_in_if.sink     req,
	cnhv_out_if.source  rsp
);

	vec_state_t        state_q, state_d;

	// text state
	logic [BIN_AW-1:0] prev_q, sprev_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  sum_q;
	logic [INV_W-1:0]  inv_q;
	logic              sat_q;

	// per-character work registers
	logic [BIN_AW-1:0] addr_q, tri_idx_q;
	logic              tri_q, has_tri_q, last_q;

	// bin store
	logic [BIN_W-1:0]      bin_mem [DIMENSIONS];
	logic [DIMENSIONS-1:0] bin_vld_q;
	logic [BIN_W-1:0]      rd_data_q;
	logic                  rd_vld_q;
	logic [BIN_AW-1:0]     rd_addr;

	// read path and result register
	logic [PROD_W-1:0]  prod_q;
	logic               out_v_q;
	logic               kind_q;
	logic [VALUE_W-1:0] value_q;
	logic [CNT_W-1:0]   seen_q;
	logic               osat_q;

	logic               accept, text_full, slot_free, load_out, mem_we, rs_start;
	op_t                op;
	logic [CHAR_W-1:0]  low_char;
	logic [BIN_AW-1:0]  bi_idx, tri_idx;
	logic [BIN_W-1:0]   old_bin, upd_bin;
	logic [BIN_W:0]     raw_bin;
	logic               bin_sat;
	logic [1:0]         amount, delta;
	logic [BIN_W:0]     pair_sum;
	logic [BIN_W+2:0]   grow;
	logic [SUM_W:0]     total;
	logic               sum_sat;
	logic [PROD_W-FRAC_SHIFT-1:0] scaled;
	logic [VALUE_W-1:0] read_value;
	logic               rs_done;
	logic [INV_W-1:0]   rs_value;

	assign op        = op_t'(req.operation);
	assign req.ready = (state_q == VS_IDLE);
	assign accept    = req.valid && req.ready;
	assign text_full = (cnt_q >= CNT_W'(MAX_TEXT_CHARS));
	assign slot_free = !out_v_q || rsp.ready;

	// lower-case ascii and hash the new n-grams
	always_comb begin
		low_char = req.char_code;
		if (req.char_code >= 16'h0041 && req.char_code <= 16'h005A) begin
			low_char = req.char_code + 16'h0020;
		end
		bi_idx  = BIN_AW'(prev_q * BIN_AW'(HASH_B)) + low_char[BIN_AW-1:0];
		tri_idx = BIN_AW'(sprev_q * BIN_AW'(HASH_A)) + bi_idx;
	end

	// bin update: saturating add and the change in the sum of squares
	always_comb begin
		old_bin  = rd_vld_q ? rd_data_q : '0;
		amount   = tri_q ? 2'd3 : 2'd2;
		raw_bin  = {1'b0, old_bin} + (BIN_W+1)'(amount);
		bin_sat  = (raw_bin > {1'b0, BIN_MAX});
		upd_bin  = bin_sat ? BIN_MAX : raw_bin[BIN_W-1:0];
		delta    = 2'(upd_bin - old_bin);
		pair_sum = {1'b0, upd_bin} + {1'b0, old_bin};
		grow     = (delta[0] ? (BIN_W+3)'(pair_sum) : '0)
		         + (delta[1] ? (BIN_W+3)'({pair_sum, 1'b0}) : '0);
		total    = {1'b0, sum_q} + (SUM_W+1)'(grow);
		sum_sat  = (sum_q == '1) || total[SUM_W];
	end

	// scaled read value, limited to 1.0
	always_comb begin
		scaled     = prod_q[PROD_W-1:FRAC_SHIFT];
		read_value = (scaled > (PROD_W-FRAC_SHIFT)'(ONE_Q15)) ? VALUE_W'(ONE_Q15)
		                                                      : scaled[VALUE_W-1:0];
	end

	// store read address
	always_comb begin
		if (state_q == VS_LOOK) begin
			rd_addr = addr_q;
		end else if (op == OP_READ) begin
			rd_addr = req.bin_index;
		end else begin
			rd_addr = bi_idx;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			VS_IDLE: begin
				if (accept) begin
					unique case (op)
						OP_CHAR: begin
							if (!text_full && cnt_q != '0) begin
								state_d = VS_ADD;
							end else if (req.last_char) begin
								state_d = VS_NORM;
							end
						end
						OP_READ:  state_d = VS_MUL;
						OP_CLEAR: state_d = VS_IDLE;
						OP_NOP:   state_d = VS_IDLE;
					endcase
				end
			end
			VS_ADD: begin
				if (!tri_q && has_tri_q) begin
					state_d = VS_LOOK;
				end else if (last_q) begin
					state_d = VS_NORM;
				end else begin
					state_d = VS_IDLE;
				end
			end
			VS_LOOK: state_d = VS_ADD;
			VS_NORM: state_d = (sum_q == '0) ? VS_STAT : VS_WAIT;
			VS_WAIT: if (rs_done) state_d = VS_STAT;
			VS_STAT: if (slot_free) state_d = VS_IDLE;
			VS_MUL:  state_d = VS_OUT;
			VS_OUT:  if (slot_free) state_d = VS_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		mem_we   = (state_q == VS_ADD);
		rs_start = (state_q == VS_NORM) && (sum_q != '0);
		load_out = (state_q == VS_STAT || state_q == VS_OUT) && slot_free;
	end

	// inverse square root unit
	cnhv_rsqrt u_rsqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rs_start),
		.sum    (sum_q),
		.done   (rs_done),
		.value  (rs_value)
	);

	// control and text state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= VS_IDLE;
			prev_q    <= '0;
			sprev_q   <= '0;
			cnt_q     <= '0;
			sum_q     <= '0;
			inv_q     <= '0;
			sat_q     <= 1'b0;
			bin_vld_q <= '0;
			rd_vld_q  <= 1'b0;
			tri_q     <= 1'b0;
			has_tri_q <= 1'b0;
			last_q    <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_vld_q <= bin_vld_q[rd_addr];

			if (accept && op == OP_CLEAR) begin
				prev_q    <= '0;
				sprev_q   <= '0;
				cnt_q     <= '0;
				sum_q     <= '0;
				inv_q     <= '0;
				sat_q     <= 1'b0;
				bin_vld_q <= '0;
			end

			// new character: history, count and n-gram flags
			if (accept && op == OP_CHAR) begin
				last_q <= req.last_char;
				tri_q  <= 1'b0;
				if (text_full) begin
					sat_q <= 1'b1;
				end else begin
					prev_q    <= low_char[BIN_AW-1:0];
					sprev_q   <= prev_q;
					cnt_q     <= cnt_q + 1'b1;
					has_tri_q <= (cnt_q >= CNT_W'(2));
				end
			end

			// bin write-back and sum of squares
			if (mem_we) begin
				bin_vld_q[addr_q] <= 1'b1;
				if (bin_sat || sum_sat) begin
					sat_q <= 1'b1;
				end
				sum_q <= sum_sat ? '1 : total[SUM_W-1:0];
				if (!tri_q && has_tri_q) begin
					tri_q <= 1'b1;
				end
			end

			// inverse norm
			if (state_q == VS_NORM && sum_q == '0) begin
				inv_q <= '0;
			end else if (state_q == VS_WAIT && rs_done) begin
				inv_q <= rs_value;
			end

			// result register
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// bin store, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			bin_mem[addr_q] <= upd_bin;
		end
		rd_data_q <= bin_mem[rd_addr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept && op == OP_CHAR) begin
			addr_q    <= bi_idx;
			tri_idx_q <= tri_idx;
		end else if (mem_we && !tri_q && has_tri_q) begin
			addr_q <= tri_idx_q;
		end
		if (state_q == VS_MUL) begin
			prod_q <= PROD_W'(old_bin) * PROD_W'(inv_q);
		end
		if (load_out) begin
			kind_q  <= (state_q == VS_OUT) ? KIND_BIN : KIND_STATUS;
			value_q <= (state_q == VS_OUT) ? read_value : '0;
			seen_q  <= cnt_q;
			osat_q  <= sat_q;
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.result_kind = kind_q;
	assign rsp.bin_value   = value_q;
	assign rsp.chars_seen  = seen_q;
	assign rsp.saturated   = osat_q;

	// checks
	`CNHV_ASSERT_IMP(a_value_range, rsp.valid, rsp.bin_value <= VALUE_W'(ONE_Q15), "bin value above one")
	`CNHV_ASSERT_IMP(a_status_zero, rsp.valid && rsp.result_kind == KIND_STATUS, rsp.bin_value == '0, "status carries a value")
	`CNHV_ASSERT_IMP(a_done_in_wait, rs_done, state_q == VS_WAIT, "root unit finished outside wait")
	`CNHV_ASSERT_NXT(a_count_step, accept && op == OP_CHAR && !text_full, cnt_q == $past(cnt_q) + 1'b1, "character count did not advance")

endmodule
